### rtl/istrs_pkg.sv
// Shared types and constants for the implicit search tree rank/select unit.
// No dependencies; imported by every module of the block.
package istrs_pkg;

  localparam int OpW    = 3;
  localparam int PlaceW = 10;
  localparam int EntryW = 11;
  localparam int StatW  = 2;

  typedef enum logic [OpW-1:0] {
    OP_RESTART = 3'd0,
    OP_LOAD    = 3'd1,
    OP_LOOKUP  = 3'd2,
    OP_SELECT  = 3'd3,
    OP_SEEK    = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_MISS   = 2'd1,
    STAT_REJECT = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEFT,
    S_CLIMB,
    S_LOAD,
    S_UPD,
    S_WALK,
    S_FETCH,
    S_OUT
  } state_e;

  // Facts about the node currently held by the sequencer.
  typedef struct packed {
    logic has_l;
    logic has_r;
    logic is_root;
    logic is_left;
    logic key_eq;
    logic key_lt;
  } node_flags_t;

endpackage

### rtl/implicit_search_tree_rank_select_unit.sv
// Implicit search tree rank/select unit: top level with sequencer and key/count memories.
// Depends on istrs_pkg and istrs_node_unit.
//
// Keys sit in a complete binary tree laid out by index (children of node i at 2i+1 and
// 2i+2), with a subtree count per node. Write entry_count first (this also restarts the
// table), then load exactly that many keys in ascending order; queries are rejected until
// the load is complete. One word is processed at a time and in_ready_o is low while it is
// in flight. A lookup, select or seek walks one tree level per cycle (one key and one count
// memory read per level); a seek that falls off the right side climbs back up. A load
// finds the next in-order node by descending or climbing, writes the key, then updates the
// counts on the path to the root with one read-modify-write per level. Restart, rejected
// and trivially answered words go straight to the output state. No clearing pass is needed
// after reset or restart: the first count write of a node in each load sequence overwrites
// it. A finished result sits in the output register while the next word can be accepted.
module implicit_search_tree_rank_select_unit
  import istrs_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [EntryW-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OpW-1:0]       opcode_i,
  input  logic [KEY_WIDTH-1:0] item_key_i,
  input  logic [PlaceW-1:0]    place_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [StatW-1:0]     status_o,
  output logic [KEY_WIDTH-1:0] result_key_o,
  output logic [PlaceW-1:0]    result_place_o
);

  localparam int IdxW  = $clog2(DEPTH);
  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int RankW = (CntW > PlaceW) ? CntW : PlaceW;

  state_e state_q, state_d;
  op_e    op_q;
  op_e    op_in;

  logic [KEY_WIDTH-1:0] key_q;
  logic [RankW-1:0]     want_q, want_d;
  logic [RankW-1:0]     rank_q, rank_d;
  logic [IdxW-1:0]      cur_q, cur_d;
  logic                 fresh_q, fresh_d;
  logic [CntW-1:0]      size_q;
  logic [CntW-1:0]      size_cfg;
  logic [CntW-1:0]      loaded_q, loaded_d;
  logic [IdxW-1:0]      fill_q, fill_d;
  stat_e                res_stat_q, res_stat_d;
  logic [KEY_WIDTH-1:0] res_key_q, res_key_d;
  logic [PlaceW-1:0]    res_place_q, res_place_d;
  logic                 out_valid_q;
  logic [StatW-1:0]     status_q;
  logic [KEY_WIDTH-1:0] result_key_q;
  logic [PlaceW-1:0]    result_place_q;

  // memories
  logic [KEY_WIDTH-1:0] key_mem [DEPTH];
  logic [CntW-1:0]      cnt_mem [DEPTH];
  logic [KEY_WIDTH-1:0] kd_q;
  logic [CntW-1:0]      cd_q;
  logic                 kwr_en, krd_en, cwr_en, crd_en;
  logic [IdxW-1:0]      kra, cra;
  logic [CntW-1:0]      cwd;

  // node unit
  logic [IdxW-1:0] unit_node;
  logic [IdxW-1:0] left_w, right_w, parent_w;
  node_flags_t     f;

  // decision terms
  logic            accept, cfg_wr, out_load;
  logic            load_full, loaded_zero, q_bad, q_empty, sel_oob;
  logic [RankW-1:0] lc_r;
  logic            is_sel, w_eq, w_lt, w_stop_l, w_stop_r;
  logic [IdxW-1:0] walk_next, walk_left;

  assign op_in       = op_e'(opcode_i);
  assign in_ready_o  = state_q == S_IDLE;
  assign accept      = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign size_cfg = (int'(cfg_data_i) > DEPTH) ? CntW'(DEPTH) : CntW'(cfg_data_i);

  assign unit_node = (state_q == S_IDLE) ? fill_q : cur_q;

  istrs_node_unit #(
    .IDX_W    (IdxW),
    .CNT_W    (CntW),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_node (
    .node_i    (unit_node),
    .size_i    (size_q),
    .probe_i   (key_q),
    .node_key_i(kd_q),
    .left_o    (left_w),
    .right_o   (right_w),
    .parent_o  (parent_w),
    .flags_o   (f)
  );

  assign load_full   = loaded_q >= size_q;
  assign loaded_zero = loaded_q == '0;
  assign q_bad       = !(op_in == OP_LOOKUP || op_in == OP_SELECT || op_in == OP_SEEK) ||
                       (loaded_q != size_q);
  assign q_empty     = size_q == '0;
  // root count equals n once the load is complete
  assign sel_oob     = (op_in == OP_SELECT) && (RankW'(place_i) >= RankW'(size_q));

  assign lc_r     = f.has_l ? RankW'(cd_q) : '0;
  assign is_sel   = op_q == OP_SELECT;
  assign w_eq     = is_sel ? (want_q == lc_r) : f.key_eq;
  assign w_lt     = is_sel ? (want_q < lc_r) : f.key_lt;
  assign w_stop_l = w_lt && !f.has_l;
  assign w_stop_r = !w_eq && !w_lt && !f.has_r;
  assign walk_next = w_lt ? left_w : right_w;
  assign walk_left = IdxW'({walk_next, 1'b1});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (op_in == OP_RESTART) begin
            state_d = S_OUT;
          end else if (op_in == OP_LOAD) begin
            if (load_full) begin
              state_d = S_OUT;
            end else if (loaded_zero || f.has_r) begin
              state_d = S_LEFT;
            end else begin
              state_d = S_CLIMB;
            end
          end else if (q_bad || q_empty || sel_oob) begin
            state_d = S_OUT;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_LEFT: begin
        if (!f.has_l) begin
          state_d = S_LOAD;
        end
      end
      S_CLIMB: begin
        if (f.is_root) begin
          state_d = S_OUT;
        end else if (f.is_left) begin
          state_d = (op_q == OP_LOAD) ? S_LOAD : S_FETCH;
        end
      end
      S_LOAD: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        if (f.is_root) begin
          state_d = S_OUT;
        end
      end
      S_WALK: begin
        if (w_eq || w_stop_l) begin
          state_d = S_OUT;
        end else if (w_stop_r) begin
          state_d = (op_q == OP_SEEK) ? S_CLIMB : S_OUT;
        end
      end
      S_FETCH: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cur_d       = cur_q;
    rank_d      = rank_q;
    want_d      = want_q;
    fresh_d     = fresh_q;
    loaded_d    = loaded_q;
    fill_d      = fill_q;
    res_stat_d  = res_stat_q;
    res_key_d   = res_key_q;
    res_place_d = res_place_q;
    kwr_en      = 1'b0;
    krd_en      = 1'b0;
    kra         = '0;
    cwr_en      = 1'b0;
    crd_en      = 1'b0;
    cra         = '0;
    cwd         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_stat_d  = STAT_OK;
          res_key_d   = '0;
          res_place_d = '0;
          rank_d      = '0;
          want_d      = RankW'(place_i);
          cur_d       = '0;
          priority if (op_in == OP_RESTART) begin
            loaded_d = '0;
            fill_d   = '0;
          end else if (op_in == OP_LOAD) begin
            if (load_full) begin
              res_stat_d = STAT_REJECT;
            end else if (!loaded_zero && f.has_r) begin
              cur_d = right_w;
            end else if (!loaded_zero) begin
              cur_d = fill_q;
            end
          end else if (q_bad) begin
            res_stat_d = STAT_REJECT;
          end else if (q_empty || sel_oob) begin
            res_stat_d = STAT_MISS;
          end else begin
            krd_en = 1'b1;
            kra    = '0;
            crd_en = 1'b1;
            cra    = IdxW'(1);
          end
        end
      end
      S_LEFT: begin
        if (f.has_l) begin
          cur_d = left_w;
        end
      end
      S_CLIMB: begin
        if (f.is_root) begin
          res_stat_d = (op_q == OP_LOAD) ? STAT_REJECT : STAT_MISS;
        end else begin
          cur_d = parent_w;
          if (f.is_left && op_q == OP_SEEK) begin
            krd_en = 1'b1;
            kra    = parent_w;
          end
        end
      end
      S_LOAD: begin
        kwr_en   = 1'b1;
        fill_d   = cur_q;
        loaded_d = loaded_q + CntW'(1);
        // a node with no left child is the first of its subtree to load
        fresh_d  = !f.has_l;
        crd_en   = 1'b1;
        cra      = cur_q;
      end
      S_UPD: begin
        cwr_en = 1'b1;
        cwd    = fresh_q ? CntW'(1) : cd_q + CntW'(1);
        if (f.is_root) begin
          res_stat_d = STAT_OK;
        end else begin
          cur_d   = parent_w;
          fresh_d = fresh_q && f.is_left;
          crd_en  = 1'b1;
          cra     = parent_w;
        end
      end
      S_WALK: begin
        if (w_eq) begin
          res_stat_d = STAT_OK;
          res_key_d  = kd_q;
          if (op_q == OP_LOOKUP) begin
            res_place_d = PlaceW'(rank_q + lc_r);
          end
        end else if (w_stop_l) begin
          if (op_q == OP_SEEK) begin
            res_stat_d = STAT_OK;
            res_key_d  = kd_q;
          end else begin
            res_stat_d = STAT_MISS;
          end
        end else if (w_stop_r) begin
          if (op_q != OP_SEEK) begin
            res_stat_d = STAT_MISS;
          end
        end else begin
          cur_d  = walk_next;
          krd_en = 1'b1;
          kra    = walk_next;
          crd_en = 1'b1;
          cra    = walk_left;
          if (!w_lt) begin
            rank_d = rank_q + lc_r + RankW'(1);
            want_d = want_q - lc_r - RankW'(1);
          end
        end
      end
      S_FETCH: begin
        res_stat_d = STAT_OK;
        res_key_d  = kd_q;
      end
      S_OUT: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (kwr_en) begin
      key_mem[cur_q] <= key_q;
    end
    if (krd_en) begin
      kd_q <= key_mem[kra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cwr_en) begin
      cnt_mem[cur_q] <= cwd;
    end
    if (crd_en) begin
      cd_q <= cnt_mem[cra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= '0;
      loaded_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        size_q   <= size_cfg;
        loaded_q <= '0;
        fill_q   <= '0;
      end else begin
        loaded_q <= loaded_d;
        fill_q   <= fill_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_in;
      key_q <= item_key_i;
    end
    cur_q       <= cur_d;
    rank_q      <= rank_d;
    want_q      <= want_d;
    fresh_q     <= fresh_d;
    res_stat_q  <= res_stat_d;
    res_key_q   <= res_key_d;
    res_place_q <= res_place_d;
    if (out_load) begin
      status_q       <= res_stat_q;
      result_key_q   <= res_key_q;
      result_place_q <= res_place_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_key_o   = result_key_q;
  assign result_place_o = result_place_q;

endmodule

### rtl/istrs_node_unit.sv
// Shared node step unit: child/parent index arithmetic and the key compare.
// Depends on istrs_pkg.
module istrs_node_unit
  import istrs_pkg::*;
#(
  parameter int IDX_W     = 10,
  parameter int CNT_W     = 11,
  parameter int KEY_WIDTH = 32
) (
  input  logic [IDX_W-1:0]     node_i,
  input  logic [CNT_W-1:0]     size_i,
  input  logic [KEY_WIDTH-1:0] probe_i,
  input  logic [KEY_WIDTH-1:0] node_key_i,
  output logic [IDX_W-1:0]     left_o,
  output logic [IDX_W-1:0]     right_o,
  output logic [IDX_W-1:0]     parent_o,
  output node_flags_t          flags_o
);

  localparam int ChW = IDX_W + 2;

  logic [ChW-1:0]   left_w;
  logic [ChW-1:0]   right_w;
  logic [ChW-1:0]   size_w;
  logic [IDX_W-1:0] pm1_w;

  assign left_w   = {1'b0, node_i, 1'b1};
  assign right_w  = {1'b0, node_i, 1'b0} + ChW'(2);
  assign size_w   = ChW'(size_i);
  assign pm1_w    = node_i - IDX_W'(1);

  assign left_o   = left_w[IDX_W-1:0];
  assign right_o  = right_w[IDX_W-1:0];
  assign parent_o = IDX_W'(pm1_w >> 1);

  assign flags_o.has_l   = left_w < size_w;
  assign flags_o.has_r   = right_w < size_w;
  assign flags_o.is_root = node_i == '0;
  assign flags_o.is_left = node_i[0];
  assign flags_o.key_eq  = probe_i == node_key_i;
  assign flags_o.key_lt  = probe_i < node_key_i;

endmodule
